@@ rtl/irfd_pkg.sv @@
// ----------------------------------------------------------------------------
// irfd_pkg
// Shared types and constants of the infrared pulse-width frame decoder.
// ----------------------------------------------------------------------------
package irfd_pkg;

   localparam int MAX_CODE_BITS_DEF = 20;

   localparam int US_W      = 12;
   localparam int KIND_W    = 2;
   localparam int CNT_W     = 5;
   localparam int RAW_W     = 20;
   localparam int ADDR_W    = 8;
   localparam int ADDR_S_W  = 5;
   localparam int CMD_W     = 7;
   localparam int CSR_IDX_W = 8;
   localparam int PHASE_W   = 2;

   typedef logic [US_W-1:0]      us_type;
   typedef logic [KIND_W-1:0]    kind_type;
   typedef logic [CNT_W-1:0]     cnt_type;
   typedef logic [RAW_W-1:0]     raw_type;
   typedef logic [ADDR_W-1:0]    addr_type;
   typedef logic [CMD_W-1:0]     cmd_type;
   typedef logic [CSR_IDX_W-1:0] csr_idx_type;

   // Item kinds
   localparam kind_type KIND_EDGE    = 2'd0;
   localparam kind_type KIND_TIMEOUT = 2'd1;
   localparam kind_type KIND_RELEASE = 2'd2;

   // Register indexes
   localparam csr_idx_type CSR_HDR_MIN = 8'd0;
   localparam csr_idx_type CSR_BIT_MIN = 8'd1;
   localparam csr_idx_type CSR_BIT_MAX = 8'd2;
   localparam csr_idx_type CSR_SPLIT   = 8'd3;

   // Register reset values
   localparam us_type HDR_MIN_RST = 12'd2000;
   localparam us_type BIT_MIN_RST = 12'd300;
   localparam us_type BIT_MAX_RST = 12'd1600;
   localparam us_type SPLIT_RST   = 12'd900;

   // Valid frame lengths
   localparam cnt_type LEN_SHORT  = 5'd12;
   localparam cnt_type LEN_MEDIUM = 5'd15;
   localparam cnt_type LEN_LONG   = 5'd20;
   localparam cnt_type CNT_SAT    = 5'd31;

   localparam int CMD_LSB_OF_ADDR = 7;

endpackage

@@ rtl/infrared_pulse_width_frame_decoder.sv @@
// ----------------------------------------------------------------------------
// infrared_pulse_width_frame_decoder
// Decodes 12, 15 and 20 bit pulse-width infrared remote frames from a stream
// of edge, timeout and release beats; one result beat per input beat.
// ----------------------------------------------------------------------------
// The result beat is registered and appears in the cycle after its input beat is taken.
// Throughput: one beat per cycle while req_stall is low; the frame state updates
// in a single pass of compare and mask logic into the state and result registers.
// req_stall rises only while a result beat waits under rsp_stall.
// Reset: idle phase, counter and code cleared, no frame held, thresholds at
// their default values, no result pending.
module infrared_pulse_width_frame_decoder #(
   parameter int MAX_CODE_BITS = irfd_pkg::MAX_CODE_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   // input channel
   input  logic                   req_valid,
   output logic                   req_stall,
   input  irfd_pkg::kind_type     req_kind,
   input  irfd_pkg::us_type       req_interval_us,
   input  logic                   req_pin_level,
   // result channel
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_frame_ready,
   output irfd_pkg::raw_type      rsp_raw_code,
   output irfd_pkg::cnt_type      rsp_bit_total,
   output irfd_pkg::addr_type     rsp_device_address,
   output irfd_pkg::cmd_type      rsp_command_code,
   // configuration
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  irfd_pkg::csr_idx_type  csr_index,
   input  irfd_pkg::us_type       csr_data
);
   import irfd_pkg::*;

   localparam int CODE_W = MAX_CODE_BITS;
   localparam int SHOW_W = (MAX_CODE_BITS > RAW_W) ? MAX_CODE_BITS : RAW_W;

   localparam logic [PHASE_W-1:0] PH_IDLE  = 2'd0;
   localparam logic [PHASE_W-1:0] PH_START = 2'd1;
   localparam logic [PHASE_W-1:0] PH_DATA  = 2'd2;

   // Threshold registers
   us_type hdr_min_ff, bit_min_ff, bit_max_ff, split_ff;

   // Frame state
   logic [PHASE_W-1:0] phase_ff, phase_in;
   cnt_type            cnt_ff, cnt_in;
   logic [CODE_W-1:0]  code_ff, code_in;
   logic               held_ff, held_in;

   // Result register
   logic     rsp_valid_ff;
   logic     ready_ff;
   raw_type  raw_ff;
   cnt_type  total_ff;
   addr_type addr_ff;
   cmd_type  cmd_ff;

   logic              req_take;
   logic              len_ok;
   logic [CODE_W-1:0] bit_mask;
   logic [SHOW_W-1:0] code_show;
   addr_type          addr_in;

   assign csr_ready = 1'b1;
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign req_take  = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_min_ff <= HDR_MIN_RST;
         bit_min_ff <= BIT_MIN_RST;
         bit_max_ff <= BIT_MAX_RST;
         split_ff   <= SPLIT_RST;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_HDR_MIN: hdr_min_ff <= csr_data;
            CSR_BIT_MIN: bit_min_ff <= csr_data;
            CSR_BIT_MAX: bit_max_ff <= csr_data;
            CSR_SPLIT:   split_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   // One-hot of the bit position about to be filled; empty once past the top
   always_comb begin
      for (int i = 0; i < CODE_W; i++) begin
         bit_mask[i] = (cnt_ff == CNT_W'(i));
      end
   end

   assign len_ok = (cnt_ff == LEN_SHORT) || (cnt_ff == LEN_MEDIUM) ||
                   (cnt_ff == LEN_LONG);

   always_comb begin
      phase_in = phase_ff;
      cnt_in   = cnt_ff;
      code_in  = code_ff;
      held_in  = held_ff;
      case (req_kind)
         KIND_EDGE: begin
            if (!held_ff) begin
               case (phase_ff)
                  PH_START: begin
                     phase_in = (req_interval_us < hdr_min_ff) ? PH_IDLE : PH_DATA;
                  end
                  PH_DATA: begin
                     if (req_pin_level) begin
                        if (req_interval_us > bit_max_ff ||
                            req_interval_us < bit_min_ff) begin
                           phase_in = PH_IDLE;
                        end else begin
                           if (req_interval_us >= split_ff) begin
                              code_in = code_ff | bit_mask;
                           end
                           if (cnt_ff != CNT_SAT) begin
                              cnt_in = cnt_ff + 1'b1;
                           end
                        end
                     end
                  end
                  default: begin
                     // open a new frame
                     cnt_in   = '0;
                     code_in  = '0;
                     phase_in = PH_START;
                  end
               endcase
            end
         end
         KIND_TIMEOUT: begin
            if (phase_ff != PH_IDLE) begin
               phase_in = PH_IDLE;
               if (len_ok) begin
                  held_in = 1'b1;
               end
            end
         end
         KIND_RELEASE: begin
            held_in  = 1'b0;
            phase_in = PH_IDLE;
         end
         default: ;
      endcase
   end

   assign code_show = SHOW_W'(code_in);

   always_comb begin
      addr_in = '0;
      if (held_in) begin
         if (cnt_in == LEN_SHORT) begin
            addr_in = ADDR_W'(code_show[CMD_LSB_OF_ADDR +: ADDR_S_W]);
         end else begin
            addr_in = code_show[CMD_LSB_OF_ADDR +: ADDR_W];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         cnt_ff       <= '0;
         code_ff      <= '0;
         held_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_take) begin
            phase_ff     <= phase_in;
            cnt_ff       <= cnt_in;
            code_ff      <= code_in;
            held_ff      <= held_in;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Result payload; hold while stalled
   always_ff @(posedge clock) begin
      if (req_take) begin
         ready_ff <= held_in;
         raw_ff   <= code_show[RAW_W-1:0];
         total_ff <= cnt_in;
         addr_ff  <= addr_in;
         cmd_ff   <= code_show[CMD_W-1:0];
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_frame_ready    = ready_ff;
   assign rsp_raw_code       = raw_ff;
   assign rsp_bit_total      = total_ff;
   assign rsp_device_address = addr_ff;
   assign rsp_command_code   = cmd_ff;

   // A held frame always has a legal length and sits in idle
   a_held_len: assert property (@(posedge clock) disable iff (reset)
      held_ff |-> ((cnt_ff == LEN_SHORT) || (cnt_ff == LEN_MEDIUM) ||
                   (cnt_ff == LEN_LONG)))
      else $error("held frame with illegal bit count");

   a_held_idle: assert property (@(posedge clock) disable iff (reset)
      held_ff |-> (phase_ff == PH_IDLE))
      else $error("held frame outside idle phase");

   a_take_result: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (rsp_valid_ff && total_ff == cnt_ff && ready_ff == held_ff))
      else $error("taken beat did not produce a matching result");

   a_no_addr_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !ready_ff) |-> (addr_ff == '0))
      else $error("address shown without a held frame");

endmodule

@@ verif/irfd_frame_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irfd_frame_checker
// Follows the request and register beats of the infrared frame decoder,
// tracks the frame state and thresholds, and compares every result beat
// field by field with the oldest predicted frame status.
// ----------------------------------------------------------------------------
module irfd_frame_checker #(
   parameter int MAX_CODE_BITS = irfd_pkg::MAX_CODE_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  irfd_pkg::kind_type    req_kind,
   input  irfd_pkg::us_type      req_interval_us,
   input  logic                  req_pin_level,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  logic                  rsp_frame_ready,
   input  irfd_pkg::raw_type     rsp_raw_code,
   input  irfd_pkg::cnt_type     rsp_bit_total,
   input  irfd_pkg::addr_type    rsp_device_address,
   input  irfd_pkg::cmd_type     rsp_command_code,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  irfd_pkg::csr_idx_type csr_index,
   input  irfd_pkg::us_type      csr_data,
   output int                    fail_count,
   output int                    pending,
   output int                    checked
);
   import irfd_pkg::*;

   typedef enum logic [PHASE_W-1:0] {TRK_IDLE, TRK_START, TRK_DATA} trk_phase_type;

   typedef struct packed {
      logic     ready;
      raw_type  code;
      cnt_type  bits;
      addr_type addr;
      cmd_type  cmd;
   } frame_status_type;

   trk_phase_type    trk_phase;
   cnt_type          trk_bits;
   raw_type          trk_code;
   logic             trk_held;
   us_type           hdr_min;
   us_type           bit_min;
   us_type           bit_max;
   us_type           split;
   frame_status_type frame_status_q[$];

   task automatic report(input string msg);
      $display("[%0t] MISMATCH result %0d: %s", $realtime, checked, msg);
      fail_count++;
   endtask

   // Advance the tracked decoder by one request beat and queue its status.
   task automatic decode_beat(input kind_type kind, input us_type iv, input logic pin);
      frame_status_type st;
      case (kind)
         KIND_EDGE: begin
            if (!trk_held) begin
               case (trk_phase)
                  TRK_START: trk_phase = (iv < hdr_min) ? TRK_IDLE : TRK_DATA;
                  TRK_DATA: begin
                     // falling edges inside the data phase carry no mark
                     if (pin) begin
                        if (iv > bit_max || iv < bit_min) begin
                           trk_phase = TRK_IDLE;
                        end else begin
                           if (iv >= split && trk_bits < MAX_CODE_BITS)
                              trk_code[trk_bits] = 1'b1;
                           if (trk_bits != CNT_SAT)
                              trk_bits++;
                        end
                     end
                  end
                  default: begin
                     trk_bits  = '0;
                     trk_code  = '0;
                     trk_phase = TRK_START;
                  end
               endcase
            end
         end
         KIND_TIMEOUT: begin
            if (trk_phase != TRK_IDLE) begin
               trk_phase = TRK_IDLE;
               if (trk_bits == LEN_SHORT || trk_bits == LEN_MEDIUM || trk_bits == LEN_LONG)
                  trk_held = 1'b1;
            end
         end
         KIND_RELEASE: begin
            trk_held  = 1'b0;
            trk_phase = TRK_IDLE;
         end
         default: ;
      endcase

      st.ready = trk_held;
      st.code  = trk_code;
      st.bits  = trk_bits;
      st.cmd   = trk_code[CMD_W-1:0];
      if (!trk_held)
         st.addr = '0;
      else if (trk_bits == LEN_SHORT)
         st.addr = addr_type'(trk_code[CMD_LSB_OF_ADDR +: ADDR_S_W]);
      else
         st.addr = trk_code[CMD_LSB_OF_ADDR +: ADDR_W];
      frame_status_q.push_back(st);
   endtask

   always @(posedge clock) begin
      frame_status_type want;
      if (reset) begin
         trk_phase = TRK_IDLE;
         trk_bits  = '0;
         trk_code  = '0;
         trk_held  = 1'b0;
         hdr_min   = HDR_MIN_RST;
         bit_min   = BIT_MIN_RST;
         bit_max   = BIT_MAX_RST;
         split     = SPLIT_RST;
         frame_status_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_HDR_MIN: hdr_min = csr_data;
               CSR_BIT_MIN: bit_min = csr_data;
               CSR_BIT_MAX: bit_max = csr_data;
               CSR_SPLIT:   split   = csr_data;
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (frame_status_q.size() == 0) begin
               report("result beat with no status waiting");
            end else begin
               want = frame_status_q.pop_front();
               if (rsp_frame_ready !== want.ready)
                  report($sformatf("frame_ready got %0b expected %0b",
                                   rsp_frame_ready, want.ready));
               if (rsp_raw_code !== want.code)
                  report($sformatf("raw_code got 0x%05h expected 0x%05h",
                                   rsp_raw_code, want.code));
               if (rsp_bit_total !== want.bits)
                  report($sformatf("bit_total got %0d expected %0d",
                                   rsp_bit_total, want.bits));
               if (rsp_device_address !== want.addr)
                  report($sformatf("device_address got 0x%02h expected 0x%02h",
                                   rsp_device_address, want.addr));
               if (rsp_command_code !== want.cmd)
                  report($sformatf("command_code got 0x%02h expected 0x%02h",
                                   rsp_command_code, want.cmd));
               checked++;
            end
         end
         if (req_valid && !req_stall)
            decode_beat(req_kind, req_interval_us, req_pin_level);
      end
      pending = frame_status_q.size();
   end

endmodule

@@ verif/infrared_pulse_width_frame_decoder_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// infrared_pulse_width_frame_decoder_tb
// Drives edge, timeout and release beats through the frame decoder: a short
// directed frame first, then random well-formed, broken and noisy frames
// under several threshold settings and idle mixes on both channels.
// ----------------------------------------------------------------------------
module infrared_pulse_width_frame_decoder_tb;
   import irfd_pkg::*;

   localparam int       CYCLE_LIMIT = 400000;
   localparam int       US_MAX      = (1 << US_W) - 1;
   localparam int       IDX_MAX     = (1 << CSR_IDX_W) - 1;
   localparam kind_type KIND_UNUSED = 2'd3;

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   kind_type    req_kind        = KIND_EDGE;
   us_type      req_interval_us = '0;
   logic        req_pin_level   = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_frame_ready;
   raw_type     rsp_raw_code;
   cnt_type     rsp_bit_total;
   addr_type    rsp_device_address;
   cmd_type     rsp_command_code;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   csr_idx_type csr_index = '0;
   us_type      csr_data  = '0;

   int fail_count;
   int pending;
   int checked;

   int send_idle_pct  = 27;
   int stall_pct      = 79;
   int beats_sent     = 0;
   int items_counted  = 0;
   int settings_used  = 0;
   int cycle_count    = 0;

   // thresholds last written, used only to shape marks
   us_type cfg_hdr_min = HDR_MIN_RST;
   us_type cfg_bit_min = BIT_MIN_RST;
   us_type cfg_bit_max = BIT_MAX_RST;
   us_type cfg_split   = SPLIT_RST;

   infrared_pulse_width_frame_decoder u_top (.*);

   irfd_frame_checker u_check (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(negedge clock)
      rsp_stall <= reset ? 1'b0 : ($urandom_range(99) < stall_pct);

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("infrared_pulse_width_frame_decoder test failed");
         $finish;
      end
   end

   // Hold the beat until it is taken; leaves time at the following falling edge.
   task automatic send_beat(input kind_type kind, input us_type iv, input logic pin,
                            input bit counts);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_kind        <= kind;
      req_interval_us <= iv;
      req_pin_level   <= pin;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      beats_sent++;
      if (counts)
         items_counted++;
   endtask

   task automatic wait_drain();
      req_valid <= 1'b0;
      while (pending != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(input csr_idx_type idx, input us_type data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
   endtask

   task automatic apply_thresholds(input us_type s_min, input us_type b_min,
                                   input us_type b_max, input us_type sp);
      wait_drain();
      write_reg(CSR_HDR_MIN, s_min);
      write_reg(CSR_BIT_MIN, b_min);
      write_reg(CSR_BIT_MAX, b_max);
      write_reg(CSR_SPLIT, sp);
      // unmapped index: must leave every threshold alone
      write_reg(csr_idx_type'($urandom_range(IDX_MAX, CSR_SPLIT + 1)), us_type'($urandom));
      csr_valid   <= 1'b0;
      cfg_hdr_min = s_min;
      cfg_bit_min = b_min;
      cfg_bit_max = b_max;
      cfg_split   = sp;
      settings_used++;
   endtask

   function automatic us_type pick_between(input int lo, input int hi);
      if (hi < lo)
         return us_type'($urandom_range(US_MAX));
      return us_type'($urandom_range(hi, lo));
   endfunction

   function automatic us_type zero_mark();
      int hi;
      hi = int'(cfg_split) - 1;
      if (hi > int'(cfg_bit_max))
         hi = int'(cfg_bit_max);
      return pick_between(int'(cfg_bit_min), hi);
   endfunction

   function automatic us_type one_mark();
      int lo;
      lo = (cfg_split > cfg_bit_min) ? int'(cfg_split) : int'(cfg_bit_min);
      return pick_between(lo, int'(cfg_bit_max));
   endfunction

   function automatic us_type bad_mark();
      if (cfg_bit_min != 0 && (cfg_bit_max == US_MAX || $urandom_range(1)))
         return pick_between(0, int'(cfg_bit_min) - 1);
      if (cfg_bit_max != US_MAX)
         return pick_between(int'(cfg_bit_max) + 1, US_MAX);
      return us_type'($urandom);
   endfunction

   task automatic send_frame(input int nbits, input bit broken);
      int bad_at;
      bad_at = broken ? $urandom_range(nbits) : -1;
      send_beat(KIND_EDGE, us_type'($urandom), 1'b0, 1'b1);
      send_beat(KIND_EDGE, pick_between(int'(cfg_hdr_min), US_MAX), 1'b1, 1'b1);
      for (int i = 0; i < nbits; i++) begin
         if ($urandom_range(3) != 0)
            send_beat(KIND_EDGE, us_type'($urandom_range(700, 400)), 1'b0, 1'b0);
         if (i == bad_at)
            send_beat(KIND_EDGE, bad_mark(), 1'b1, 1'b1);
         else if ($urandom_range(1))
            send_beat(KIND_EDGE, one_mark(), 1'b1, 1'b1);
         else
            send_beat(KIND_EDGE, zero_mark(), 1'b1, 1'b1);
      end
      if ($urandom_range(9) != 0)
         send_beat(KIND_TIMEOUT, us_type'($urandom), 1'($urandom_range(1)), 1'b1);
      // stray edge, dropped if the frame got held
      if ($urandom_range(3) == 0)
         send_beat(KIND_EDGE, us_type'($urandom), 1'($urandom_range(1)), 1'b0);
      if ($urandom_range(4) != 0)
         send_beat(KIND_RELEASE, us_type'($urandom), 1'($urandom_range(1)), 1'b1);
   endtask

   // Send random beats until about target more have been taken.
   task automatic run_random(input int target);
      int       stop_at;
      int       nbits;
      kind_type k;
      stop_at = beats_sent + target;
      while (beats_sent < stop_at) begin
         if ($urandom_range(9) < 2) begin
            repeat ($urandom_range(4, 1)) begin
               k = kind_type'($urandom_range(3));
               send_beat(k, us_type'($urandom), 1'($urandom_range(1)), k != KIND_UNUSED);
            end
         end else begin
            if ($urandom_range(9) < 6) begin
               case ($urandom_range(2))
                  0: nbits = int'(LEN_SHORT);
                  1: nbits = int'(LEN_MEDIUM);
                  default: nbits = int'(LEN_LONG);
               endcase
            end else begin
               nbits = $urandom_range(34);
            end
            send_frame(nbits, $urandom_range(6) == 0);
         end
      end
   endtask

   initial begin
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: idle-state oddities, short start mark, then one 12-bit frame
      send_beat(KIND_TIMEOUT, us_type'(US_MAX), 1'b1, 1'b1);
      send_beat(KIND_UNUSED, '0, 1'b0, 1'b0);
      send_beat(KIND_RELEASE, '0, 1'b0, 1'b1);
      send_beat(KIND_EDGE, us_type'(US_MAX), 1'b0, 1'b1);
      send_beat(KIND_EDGE, HDR_MIN_RST - 1'b1, 1'b1, 1'b1);
      send_beat(KIND_EDGE, '0, 1'b0, 1'b1);
      send_beat(KIND_EDGE, HDR_MIN_RST, 1'b1, 1'b1);
      send_beat(KIND_EDGE, 12'd600, 1'b0, 1'b0);
      send_beat(KIND_EDGE, BIT_MIN_RST, 1'b1, 1'b1);
      send_beat(KIND_EDGE, SPLIT_RST - 1'b1, 1'b1, 1'b1);
      send_beat(KIND_EDGE, SPLIT_RST, 1'b1, 1'b1);
      send_beat(KIND_EDGE, BIT_MAX_RST, 1'b1, 1'b1);
      for (int i = 0; i < 8; i++)
         send_beat(KIND_EDGE, (i % 3 == 0) ? BIT_MIN_RST : BIT_MAX_RST, 1'b1, 1'b1);
      send_beat(KIND_TIMEOUT, '0, 1'b0, 1'b1);
      send_beat(KIND_EDGE, HDR_MIN_RST, 1'b1, 1'b0);
      send_beat(KIND_RELEASE, '0, 1'b1, 1'b1);
      send_beat(KIND_EDGE, '0, 1'b0, 1'b1);
      send_beat(KIND_EDGE, us_type'(US_MAX), 1'b1, 1'b1);
      send_beat(KIND_EDGE, BIT_MAX_RST + 1'b1, 1'b1, 1'b1);

      apply_thresholds(HDR_MIN_RST, BIT_MIN_RST, BIT_MAX_RST, SPLIT_RST);
      run_random(270);
      wait_drain();
      run_random(130);

      send_idle_pct = 79;
      stall_pct     = 27;
      apply_thresholds('0, '0, us_type'(US_MAX), '0);
      run_random(190);
      apply_thresholds(us_type'(US_MAX), us_type'(US_MAX), '0, us_type'(US_MAX));
      run_random(90);

      send_idle_pct = 0;
      stall_pct     = 0;
      repeat (3) begin
         us_type s_min, b_min, b_max;
         s_min = us_type'($urandom_range(3000));
         b_min = us_type'($urandom_range(800));
         b_max = us_type'($urandom_range(US_MAX, b_min));
         apply_thresholds(s_min, b_min, b_max, us_type'($urandom_range(b_max, b_min)));
         run_random(210);
      end

      req_valid <= 1'b0;
      while (pending != 0)
         @(negedge clock);
      repeat (8) @(negedge clock);

      $display("Covered %0d request beats (%0d frame events), %0d results checked",
               beats_sent, items_counted, checked);
      $display("Threshold settings: %0d, idle mixes 27/79, 79/27 and none, one full drain",
               settings_used);
      if (fail_count == 0)
         $display("infrared_pulse_width_frame_decoder test passed");
      else
         $display("infrared_pulse_width_frame_decoder test failed");
      $finish;
   end

endmodule

@@ infrared_pulse_width_frame_decoder.f @@
rtl/irfd_pkg.sv
rtl/infrared_pulse_width_frame_decoder.sv
verif/irfd_frame_checker.sv
verif/infrared_pulse_width_frame_decoder_tb.sv
